### design/sdrx_pkg.sv
// ----------------------------------------------------------------------------
// sdrx_pkg: shared types and constants for the SD SPI response/block receiver
// Item structs for both channels, function codes, card byte codes and
// status codes.
// ----------------------------------------------------------------------------
package sdrx_pkg;

    // Input item
    typedef struct packed {
        logic [1:0] func;
        logic [9:0] byte_count;
        logic [7:0] rx_byte;
    } sdrx_in_t;

    // Result item
    typedef struct packed {
        logic [7:0] data_byte;
        logic       data_valid;
        logic       done_res;
        logic [2:0] status;
    } sdrx_out_t;

    // Function codes
    localparam logic [1:0] FUNC_RESP  = 2'd0;
    localparam logic [1:0] FUNC_BLOCK = 2'd1;
    localparam logic [1:0] FUNC_BYTE  = 2'd2;

    // Bytes seen on MISO
    localparam logic [7:0] IDLE_BYTE   = 8'hFF;
    localparam logic [7:0] R1_IDLE     = 8'h01;
    localparam logic [7:0] R1_ACTIVE   = 8'h00;
    localparam logic [7:0] START_TOKEN = 8'hFE;

    // Status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_TIMEOUT   = 3'd1;
    localparam logic [2:0] ST_BAD_R1    = 3'd2;
    localparam logic [2:0] ST_BAD_TOKEN = 3'd3;
    localparam logic [2:0] ST_BAD_COUNT = 3'd4;

    // Timeout register
    localparam int         TIMEOUT_W     = 16;
    localparam logic [15:0] TIMEOUT_RESET = 16'd4096;

    // Transfer phase, one-hot
    typedef enum logic [5:0] {
        PH_IDLE       = 6'b000001,
        PH_WAIT_R1    = 6'b000010,
        PH_RESP_DATA  = 6'b000100,
        PH_WAIT_TOKEN = 6'b001000,
        PH_BLOCK_DATA = 6'b010000,
        PH_CHECK      = 6'b100000
    } phase_t;

endpackage

### design/sdrx_in_reg.sv
// ----------------------------------------------------------------------------
// sdrx_in_reg: input register
// Captures one input item and holds it until the core takes it.
// ----------------------------------------------------------------------------
module sdrx_in_reg (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  sdrx_pkg::sdrx_in_t in_data,
    input  logic              take,
    output logic              item_valid,
    output sdrx_pkg::sdrx_in_t item
);
    import sdrx_pkg::*;

    logic     valid_reg;
    logic     valid_next;
    sdrx_in_t data_reg;

    // Free when empty or when the held item leaves this cycle
    assign in_ready   = !valid_reg || take;
    assign valid_next = (in_valid && in_ready) ? 1'b1 : (take ? 1'b0 : valid_reg);

    // Valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            data_reg <= in_data;
        end
    end

    assign item_valid = valid_reg;
    assign item       = data_reg;

endmodule

### design/sdrx_core.sv
// ----------------------------------------------------------------------------
// sdrx_core: transfer state and per-item decision
// Holds phase, mode, byte and poll counters; one item is decided per cycle while take is high.
// ----------------------------------------------------------------------------
module sdrx_core #(
    parameter int MAX_BYTES = 512
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               take,
    input  sdrx_pkg::sdrx_in_t item,
    input  logic [15:0]        timeout_polls,
    output logic               res_valid,
    output sdrx_pkg::sdrx_out_t res
);
    import sdrx_pkg::*;

    localparam int CNT_W = $clog2(MAX_BYTES + 1);
    localparam int CMP_W = (CNT_W > 10) ? CNT_W : 10;

    phase_t               phase_reg, phase_next;
    logic                 block_mode_reg, block_mode_next;
    logic [CNT_W-1:0]     left_reg, left_next;
    logic [TIMEOUT_W-1:0] poll_reg, poll_next;
    logic                 chk_reg, chk_next;

    logic [CMP_W-1:0]     count_ext;
    logic [CNT_W-1:0]     count_clip;
    logic                 poll_out;
    logic                 left_last;

    // Count clamped to the buffer size
    assign count_ext  = CMP_W'(item.byte_count);
    assign count_clip = (count_ext > CMP_W'(MAX_BYTES)) ? CNT_W'(MAX_BYTES)
                                                        : CNT_W'(count_ext);
    assign poll_out   = (poll_reg >= timeout_polls);
    assign left_last  = (left_reg <= CNT_W'(1));

    // Next state and result
    always_comb
    begin
        phase_next      = phase_reg;
        block_mode_next = block_mode_reg;
        left_next       = left_reg;
        poll_next       = poll_reg;
        chk_next        = chk_reg;
        res_valid       = 1'b0;
        res             = '0;

        if (take)
        begin
            case (item.func) inside
                FUNC_RESP, FUNC_BLOCK:
                begin
                    block_mode_next = item.func[0];
                    poll_next       = '0;
                    chk_next        = 1'b0;
                    if (item.func == FUNC_BLOCK && count_clip == '0)
                    begin
                        phase_next = PH_IDLE;
                        left_next  = '0;
                        res_valid  = 1'b1;
                        res        = '{8'h00, 1'b0, 1'b1, ST_BAD_COUNT};
                    end
                    else
                    begin
                        left_next  = (count_clip == '0) ? CNT_W'(1) : count_clip;
                        phase_next = PH_WAIT_R1;
                    end
                end
                FUNC_BYTE:
                begin
                    unique case (phase_reg)
                        PH_WAIT_R1:
                        begin
                            if (item.rx_byte == IDLE_BYTE)
                            begin
                                if (poll_out)
                                begin
                                    phase_next = PH_IDLE;
                                    left_next  = '0;
                                    poll_next  = '0;
                                    chk_next   = 1'b0;
                                    res_valid  = 1'b1;
                                    res        = '{8'h00, 1'b0, 1'b1, ST_TIMEOUT};
                                end
                                else
                                begin
                                    poll_next = poll_reg + 1'b1;
                                end
                            end
                            else if (block_mode_reg)
                            begin
                                if (item.rx_byte != R1_ACTIVE)
                                begin
                                    phase_next = PH_IDLE;
                                    left_next  = '0;
                                    poll_next  = '0;
                                    chk_next   = 1'b0;
                                    res_valid  = 1'b1;
                                    res        = '{8'h00, 1'b0, 1'b1, ST_BAD_R1};
                                end
                                else
                                begin
                                    poll_next  = '0;
                                    phase_next = PH_WAIT_TOKEN;
                                end
                            end
                            else if (item.rx_byte != R1_IDLE && item.rx_byte != R1_ACTIVE)
                            begin
                                phase_next = PH_IDLE;
                                left_next  = '0;
                                poll_next  = '0;
                                chk_next   = 1'b0;
                                res_valid  = 1'b1;
                                res        = '{8'h00, 1'b0, 1'b1, ST_BAD_R1};
                            end
                            else if (left_last)
                            begin
                                phase_next = PH_IDLE;
                                left_next  = '0;
                                poll_next  = '0;
                                res_valid  = 1'b1;
                                res        = '{item.rx_byte, 1'b1, 1'b1, ST_OK};
                            end
                            else
                            begin
                                left_next  = left_reg - 1'b1;
                                phase_next = PH_RESP_DATA;
                                res_valid  = 1'b1;
                                res        = '{item.rx_byte, 1'b1, 1'b0, ST_OK};
                            end
                        end
                        PH_RESP_DATA:
                        begin
                            res_valid = 1'b1;
                            if (left_last)
                            begin
                                phase_next = PH_IDLE;
                                left_next  = '0;
                                res        = '{item.rx_byte, 1'b1, 1'b1, ST_OK};
                            end
                            else
                            begin
                                left_next = left_reg - 1'b1;
                                res       = '{item.rx_byte, 1'b1, 1'b0, ST_OK};
                            end
                        end
                        PH_WAIT_TOKEN:
                        begin
                            if (item.rx_byte == IDLE_BYTE)
                            begin
                                if (poll_out)
                                begin
                                    phase_next = PH_IDLE;
                                    left_next  = '0;
                                    poll_next  = '0;
                                    chk_next   = 1'b0;
                                    res_valid  = 1'b1;
                                    res        = '{8'h00, 1'b0, 1'b1, ST_TIMEOUT};
                                end
                                else
                                begin
                                    poll_next = poll_reg + 1'b1;
                                end
                            end
                            else if (item.rx_byte != START_TOKEN)
                            begin
                                phase_next = PH_IDLE;
                                left_next  = '0;
                                poll_next  = '0;
                                chk_next   = 1'b0;
                                res_valid  = 1'b1;
                                res        = '{8'h00, 1'b0, 1'b1, ST_BAD_TOKEN};
                            end
                            else
                            begin
                                phase_next = PH_BLOCK_DATA;
                            end
                        end
                        PH_BLOCK_DATA:
                        begin
                            res_valid = 1'b1;
                            res       = '{item.rx_byte, 1'b1, 1'b0, ST_OK};
                            if (left_last)
                            begin
                                left_next  = '0;
                                poll_next  = '0;
                                chk_next   = 1'b0;
                                phase_next = PH_CHECK;
                            end
                            else
                            begin
                                left_next = left_reg - 1'b1;
                            end
                        end
                        PH_CHECK:
                        begin
                            if (item.rx_byte == IDLE_BYTE)
                            begin
                                if (poll_out)
                                begin
                                    phase_next = PH_IDLE;
                                    left_next  = '0;
                                    poll_next  = '0;
                                    chk_next   = 1'b0;
                                    res_valid  = 1'b1;
                                    res        = '{8'h00, 1'b0, 1'b1, ST_TIMEOUT};
                                end
                                else
                                begin
                                    poll_next = poll_reg + 1'b1;
                                end
                            end
                            else if (chk_reg)
                            begin
                                // second checksum byte closes the block
                                phase_next = PH_IDLE;
                                left_next  = '0;
                                poll_next  = '0;
                                chk_next   = 1'b0;
                                res_valid  = 1'b1;
                                res        = '{8'h00, 1'b0, 1'b1, ST_OK};
                            end
                            else
                            begin
                                poll_next = '0;
                                chk_next  = 1'b1;
                            end
                        end
                        default:
                        begin
                            // idle: stray bytes are dropped
                        end
                    endcase
                end
                default:
                begin
                    // unused function code
                end
            endcase
        end
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            block_mode_reg <= 1'b0;
            left_reg       <= '0;
            poll_reg       <= '0;
            chk_reg        <= 1'b0;
        end
        else
        begin
            phase_reg      <= phase_next;
            block_mode_reg <= block_mode_next;
            left_reg       <= left_next;
            poll_reg       <= poll_next;
            chk_reg        <= chk_next;
        end
    end

endmodule

### design/sdrx_out_reg.sv
// ----------------------------------------------------------------------------
// sdrx_out_reg: result register
// Holds one result item until the downstream side takes it.
// ----------------------------------------------------------------------------
module sdrx_out_reg (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load,
    input  sdrx_pkg::sdrx_out_t res,
    output logic                free,
    output logic                out_valid,
    input  logic                out_ready,
    output sdrx_pkg::sdrx_out_t out_data
);
    import sdrx_pkg::*;

    logic      valid_reg;
    logic      valid_next;
    sdrx_out_t data_reg;

    // Room for a new result when empty or draining this cycle
    assign free       = !valid_reg || out_ready;
    assign valid_next = load ? 1'b1 : (out_ready ? 1'b0 : valid_reg);

    // Valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= res;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

### design/sd_spi_response_block_receiver_top.sv
// ----------------------------------------------------------------------------
// sd_spi_response_block_receiver_top: SD SPI-mode response and block receiver
//
// Input channel (in_valid/in_ready/in_data) carries start commands and bytes
// received on MISO. A start command opens a response read or a block read;
// idle 0xFF bytes are polled against timeout_polls, R1 and the start token
// are checked, data bytes are delivered and block checksums are dropped.
// Output channel (out_valid/out_ready/out_data) carries at most one result
// item per input item; the last item of a transfer has done_res set and
// carries the status.
// Configuration channel (cfg_valid/cfg_ready/cfg_data) writes timeout_polls;
// it is always ready and should be written only while no transfer is busy.
// An accepted item waits in the input register until the result register
// has room; its result is then registered there and shows at out_valid.
// One item per cycle while the result register has room.
// When out_ready is low the result register holds and one item waits in the
// input register; in_ready drops only when both are occupied.
// Reset: phase idle, counters clear, timeout_polls returns to 4096.
// ----------------------------------------------------------------------------
module sd_spi_response_block_receiver_top #(
    parameter int MAX_BYTES = 512
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  sdrx_pkg::sdrx_in_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output sdrx_pkg::sdrx_out_t out_data,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [15:0]         cfg_data
);
    import sdrx_pkg::*;

    logic                 item_valid;
    sdrx_in_t             item;
    logic                 out_free;
    logic                 take;
    logic                 res_valid;
    sdrx_out_t            res;
    logic [TIMEOUT_W-1:0] timeout_reg;

    // Item advances when the result register has room
    assign take      = item_valid && out_free;
    assign cfg_ready = 1'b1;

    // Timeout register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg <= TIMEOUT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            timeout_reg <= cfg_data;
        end
    end

    sdrx_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_data    (in_data),
        .take       (take),
        .item_valid (item_valid),
        .item       (item)
    );

    sdrx_core #(
        .MAX_BYTES (MAX_BYTES)
    ) u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .take          (take),
        .item          (item),
        .timeout_polls (timeout_reg),
        .res_valid     (res_valid),
        .res           (res)
    );

    sdrx_out_reg u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (take && res_valid),
        .res       (res),
        .free      (out_free),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    // A result without data must close the transfer
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.data_valid || out_data.done_res))
        else $error("result carries neither data nor done");

    // Error status only on a closing item without data
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.status != ST_OK) |->
            (out_data.done_res && !out_data.data_valid))
        else $error("error status on a data or non-final item");

    // A result is only loaded when it can be held
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |-> !take)
        else $error("core advanced while result register was full");

    // A timeout only comes after a poll byte was received
    assert property (@(posedge clk) disable iff (!rst_n)
        (take && res_valid && res.status == ST_TIMEOUT) |->
            (item.func == FUNC_BYTE && item.rx_byte == IDLE_BYTE))
        else $error("timeout without an idle byte");

endmodule

### test/tb.sv
// ----------------------------------------------------------------------------
// tb: testbench for sd_spi_response_block_receiver_top
// Drives start commands and card bytes into the receiver and predicts every
// result with a cycle-free model of the response/block read protocol. Checks
// each result field by field in order. Runs directed cases first (timeouts,
// bad R1, bad token, zero and oversized counts, aborts, stray bytes), then
// random well-formed transfers mixed with noise, under several timeout
// settings and random idling on both channels.
// ----------------------------------------------------------------------------
module tb;
    import sdrx_pkg::*;

    localparam int     BLOCK_MAX    = 512;
    localparam int     HALF_PERIOD  = 4;
    localparam int     SETTLE       = 8;       // cycles after the last result
    localparam int     SETTLE_LIMIT = 20000;   // cycles to wait for results
    localparam longint RUN_LIMIT    = 64'd8_000_000;

    // Function code the block ignores
    localparam logic [1:0] FUNC_UNUSED = 2'd3;
    localparam int         CHECK_COUNT = 2;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic        in_ready;
    sdrx_in_t    in_data   = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    sdrx_out_t   out_data;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [15:0] cfg_data  = '0;

    // Receiver state as predicted
    phase_t      m_phase   = PH_IDLE;
    logic        m_block   = 1'b0;
    logic [9:0]  m_left    = '0;
    logic [15:0] m_polls   = '0;
    logic [1:0]  m_chk     = '0;
    logic [15:0] m_timeout = TIMEOUT_RESET;
    sdrx_out_t   host_results_q[$];
    sdrx_out_t   want_res;

    // Stimulus control and bookkeeping
    int unsigned timeout_now   = TIMEOUT_RESET;
    int          in_gap_pct    = 0;
    int          out_stall_pct = 0;
    int          items_sent    = 0;
    int          items_in      = 0;
    int          results_seen  = 0;
    int          mismatches    = 0;
    int          ends_by_status[5];

    sd_spi_response_block_receiver_top #(.MAX_BYTES(BLOCK_MAX)) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #HALF_PERIOD clk = 1'b1;
        #HALF_PERIOD clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Protocol prediction
    // ------------------------------------------------------------------------
    function automatic sdrx_out_t make_result(logic [7:0] b, logic v, logic d,
                                              logic [2:0] st);
        sdrx_out_t r;
        r.data_byte  = b;
        r.data_valid = v;
        r.done_res   = d;
        r.status     = st;
        return r;
    endfunction

    // End the transfer with a done item and go idle
    function automatic void close_transfer(logic [2:0] st);
        m_phase = PH_IDLE;
        m_left  = '0;
        m_polls = '0;
        m_chk   = '0;
        host_results_q.push_back(make_result(8'h00, 1'b0, 1'b1, st));
    endfunction

    // Count one idle byte in a wait; true once the wait has run out
    function automatic bit poll_expired();
        if (m_polls >= m_timeout)
            return 1'b1;
        m_polls = m_polls + 16'd1;
        return 1'b0;
    endfunction

    // Response byte out; the last one closes the transfer
    function automatic void deliver_response(logic [7:0] b);
        if (m_left <= 10'd1)
        begin
            m_phase = PH_IDLE;
            m_left  = '0;
            m_polls = '0;
            host_results_q.push_back(make_result(b, 1'b1, 1'b1, ST_OK));
        end
        else
        begin
            m_left  = m_left - 10'd1;
            m_phase = PH_RESP_DATA;
            host_results_q.push_back(make_result(b, 1'b1, 1'b0, ST_OK));
        end
    endfunction

    function automatic void card_rx_step(sdrx_in_t it);
        int cnt;
        cnt = (it.byte_count > BLOCK_MAX) ? BLOCK_MAX : int'(it.byte_count);
        // Start command: aborts anything running
        if (it.func == FUNC_RESP || it.func == FUNC_BLOCK)
        begin
            m_block = (it.func == FUNC_BLOCK);
            m_polls = '0;
            m_chk   = '0;
            if (m_block && cnt == 0)
            begin
                m_phase = PH_IDLE;
                m_left  = '0;
                host_results_q.push_back(make_result(8'h00, 1'b0, 1'b1, ST_BAD_COUNT));
                return;
            end
            m_left  = (cnt == 0) ? 10'd1 : 10'(cnt);
            m_phase = PH_WAIT_R1;
            return;
        end
        if (it.func != FUNC_BYTE)
            return;
        case (m_phase)
            PH_WAIT_R1:
            begin
                if (it.rx_byte == IDLE_BYTE)
                begin
                    if (poll_expired())
                        close_transfer(ST_TIMEOUT);
                end
                else if (m_block)
                begin
                    if (it.rx_byte != R1_ACTIVE)
                        close_transfer(ST_BAD_R1);
                    else
                    begin
                        m_polls = '0;
                        m_phase = PH_WAIT_TOKEN;
                    end
                end
                else if (it.rx_byte != R1_IDLE && it.rx_byte != R1_ACTIVE)
                    close_transfer(ST_BAD_R1);
                else
                    deliver_response(it.rx_byte);
            end
            PH_RESP_DATA:
                deliver_response(it.rx_byte);
            PH_WAIT_TOKEN:
            begin
                if (it.rx_byte == IDLE_BYTE)
                begin
                    if (poll_expired())
                        close_transfer(ST_TIMEOUT);
                end
                else if (it.rx_byte != START_TOKEN)
                    close_transfer(ST_BAD_TOKEN);
                else
                    m_phase = PH_BLOCK_DATA;
            end
            PH_BLOCK_DATA:
            begin
                if (m_left <= 10'd1)
                begin
                    m_left  = '0;
                    m_polls = '0;
                    m_chk   = '0;
                    m_phase = PH_CHECK;
                end
                else
                    m_left = m_left - 10'd1;
                host_results_q.push_back(make_result(it.rx_byte, 1'b1, 1'b0, ST_OK));
            end
            PH_CHECK:
            begin
                if (it.rx_byte == IDLE_BYTE)
                begin
                    if (poll_expired())
                        close_transfer(ST_TIMEOUT);
                end
                else
                begin
                    m_polls = '0;
                    m_chk   = m_chk + 2'd1;
                    if (m_chk >= CHECK_COUNT)
                        close_transfer(ST_OK);
                end
            end
            default:
            begin
            end
        endcase
    endfunction

    task automatic flag_mismatch(string msg);
        mismatches++;
        $display("[%0t] mismatch: %s", $time, msg);
    endtask

    // ------------------------------------------------------------------------
    // Accepted items feed the model; results are checked in order
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
        begin
            card_rx_step(in_data);
            items_in++;
        end
        if (rst_n && cfg_valid && cfg_ready)
            m_timeout = cfg_data;
        if (rst_n && out_valid && out_ready)
        begin
            results_seen++;
            if (host_results_q.size() == 0)
                flag_mismatch($sformatf("result with nothing pending: byte %02h valid %0b done %0b status %0d",
                    out_data.data_byte, out_data.data_valid, out_data.done_res, out_data.status));
            else
            begin
                want_res = host_results_q.pop_front();
                if (out_data.data_byte !== want_res.data_byte)
                    flag_mismatch($sformatf("data_byte %02h, want %02h",
                        out_data.data_byte, want_res.data_byte));
                if (out_data.data_valid !== want_res.data_valid)
                    flag_mismatch($sformatf("data_valid %0b, want %0b",
                        out_data.data_valid, want_res.data_valid));
                if (out_data.done_res !== want_res.done_res)
                    flag_mismatch($sformatf("done_res %0b, want %0b",
                        out_data.done_res, want_res.done_res));
                if (out_data.status !== want_res.status)
                    flag_mismatch($sformatf("status %0d, want %0d",
                        out_data.status, want_res.status));
                if (want_res.done_res && want_res.status <= ST_BAD_COUNT)
                    ends_by_status[want_res.status]++;
            end
        end
    end

    // Result side back-pressure in random bursts
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (out_stall_pct > 0 && $urandom_range(0, 99) < out_stall_pct)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge clk);
            end
            out_ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    task automatic send_item(logic [1:0] f, logic [9:0] cnt, logic [7:0] b);
        sdrx_in_t it;
        it.func       = f;
        it.byte_count = cnt;
        it.rx_byte    = b;
        if (in_gap_pct > 0 && $urandom_range(0, 99) < in_gap_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        items_sent++;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    task automatic send_start(logic [1:0] f, int cnt);
        send_item(f, 10'(cnt), 8'($urandom_range(0, 255)));
    endtask

    task automatic send_byte(logic [7:0] b);
        send_item(FUNC_BYTE, 10'($urandom_range(0, 1023)), b);
    endtask

    task automatic send_polls(int n);
        repeat (n) send_byte(IDLE_BYTE);
    endtask

    // Hold off the sender until every pending result has come back
    task automatic settle_all();
        int waited;
        waited = 0;
        in_valid <= 1'b0;
        @(posedge clk);
        while (host_results_q.size() != 0 && waited < SETTLE_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        if (host_results_q.size() != 0)
            flag_mismatch($sformatf("%0d results never arrived", host_results_q.size()));
        repeat (SETTLE) @(posedge clk);
    endtask

    // Force idle with a zero-count block start, then write timeout_polls
    task automatic load_timeout(logic [15:0] v);
        send_start(FUNC_BLOCK, 0);
        settle_all();
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
        timeout_now = v;
    endtask

    function automatic int pick_count();
        int r;
        r = $urandom_range(0, 199);
        if (r < 20)
            return 0;
        if (r < 130)
            return $urandom_range(1, 6);
        if (r < 198)
            return $urandom_range(7, 40);
        if (r == 198)
            return BLOCK_MAX;
        return $urandom_range(BLOCK_MAX + 1, 1023);
    endfunction

    // Idle bytes before a wait ends; more than timeout_now means a timeout
    function automatic int pick_polls();
        int r;
        r = $urandom_range(0, 99);
        if (timeout_now <= 64 && r < 8)
            return timeout_now + 1;
        if (timeout_now <= 64 && r < 16)
            return timeout_now;
        if (r < 50)
            return 0;
        return $urandom_range(1, (timeout_now < 5) ? timeout_now : 5);
    endfunction

    // One transfer with random content; some end early on purpose
    task automatic random_transfer();
        int  cnt, len, k, i, r;
        bit  blk;
        blk = $urandom_range(0, 1);
        cnt = pick_count();
        len = (cnt > BLOCK_MAX) ? BLOCK_MAX : cnt;
        send_start(blk ? FUNC_BLOCK : FUNC_RESP, cnt);
        if (blk && len == 0)
            return;
        if (len == 0)
            len = 1;
        r = $urandom_range(0, 99);
        // start while waiting: the next start cuts this one off
        if (r < 3)
            return;
        k = pick_polls();
        send_polls(k);
        if (k > timeout_now)
            return;
        if (r < 10)
        begin
            send_byte(blk ? 8'($urandom_range(1, 254)) : 8'($urandom_range(2, 254)));
            return;
        end
        if (!blk)
        begin
            send_byte($urandom_range(0, 1) ? R1_IDLE : R1_ACTIVE);
            for (i = 1; i < len; i++)
            begin
                if ($urandom_range(0, 199) == 0)
                    return;
                send_byte(8'($urandom_range(0, 255)));
            end
            return;
        end
        send_byte(R1_ACTIVE);
        k = pick_polls();
        send_polls(k);
        if (k > timeout_now)
            return;
        if (r < 16)
        begin
            send_byte(8'($urandom_range(0, 253)));
            return;
        end
        send_byte(START_TOKEN);
        for (i = 0; i < len; i++)
        begin
            if ($urandom_range(0, 199) == 0)
                return;
            send_byte(8'($urandom_range(0, 255)));
        end
        // checksum bytes, each with its own wait
        repeat (CHECK_COUNT)
        begin
            k = pick_polls();
            send_polls(k);
            if (k > timeout_now)
                return;
            send_byte(8'($urandom_range(0, 254)));
        end
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    // Reset value of timeout_polls: a wait of 64 idle bytes still passes
    task automatic test_reset_timeout();
        in_gap_pct    = 0;
        out_stall_pct = 0;
        send_start(FUNC_RESP, 1);
        send_polls(64);
        send_byte(R1_ACTIVE);
        settle_all();
    endtask

    task automatic test_directed_response();
        load_timeout(16'd2);
        send_byte(8'h5A);                          // stray byte while idle
        send_item(FUNC_UNUSED, 10'h3FF, 8'hFF);    // ignored function
        send_start(FUNC_RESP, 0);                  // zero count reads R1 only
        send_byte(R1_IDLE);
        send_start(FUNC_RESP, 3);                  // last allowed poll
        send_polls(2);
        send_byte(R1_ACTIVE);
        send_byte(IDLE_BYTE);                      // 0xFF is data here
        send_byte(8'h80);
        send_start(FUNC_RESP, 2);                  // bad R1
        send_byte(START_TOKEN);
        send_start(FUNC_RESP, 4);                  // R1 timeout
        send_polls(3);
        settle_all();
    endtask

    task automatic test_directed_block();
        out_stall_pct = 30;
        send_start(FUNC_BLOCK, 0);                 // bad count
        send_start(FUNC_BLOCK, 2);
        send_polls(1);
        send_byte(R1_ACTIVE);
        send_polls(2);
        send_byte(START_TOKEN);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_polls(2);
        send_byte(8'h12);
        send_byte(8'hFE);
        send_start(FUNC_BLOCK, 1);                 // R1 idle is bad for a block
        send_byte(R1_IDLE);
        send_start(FUNC_BLOCK, 1);                 // bad token
        send_byte(R1_ACTIVE);
        send_byte(8'hFD);
        send_start(FUNC_BLOCK, 1);                 // token timeout
        send_byte(R1_ACTIVE);
        send_polls(3);
        send_start(FUNC_BLOCK, 3);                 // aborted mid-block
        send_byte(R1_ACTIVE);
        send_byte(START_TOKEN);
        send_byte(8'h11);
        send_start(FUNC_RESP, 1);
        send_byte(R1_ACTIVE);
        send_start(FUNC_BLOCK, 1);                 // checksum timeout
        send_byte(R1_ACTIVE);
        send_byte(START_TOKEN);
        send_byte(8'h22);
        send_byte(8'h01);
        send_polls(3);
        settle_all();
    endtask

    // Count above the maximum is clamped to BLOCK_MAX bytes
    task automatic test_large_count();
        int i;
        load_timeout(16'd1);
        in_gap_pct    = 5;
        out_stall_pct = 5;
        send_start(FUNC_RESP, 1023);
        send_byte(R1_ACTIVE);
        for (i = 1; i < BLOCK_MAX; i++)
            send_byte(8'($urandom_range(0, 255)));
        send_byte(8'h3C);                          // stray once done
        settle_all();
    endtask

    // Full 16-bit setting: a wait well inside the limit passes
    task automatic test_long_timeout();
        load_timeout(16'hFFFF);
        in_gap_pct    = 0;
        out_stall_pct = 0;
        send_start(FUNC_RESP, 2);
        send_polls(32);
        send_byte(R1_IDLE);
        send_byte(8'hA5);
        settle_all();
    endtask

    task automatic test_random_mix(int n_items, int gap_pct, int stall_pct);
        int r, stop_at;
        in_gap_pct    = gap_pct;
        out_stall_pct = stall_pct;
        stop_at       = items_sent + n_items;
        while (items_sent < stop_at)
        begin
            r = $urandom_range(0, 99);
            if (r < 6)
                send_byte(8'($urandom_range(0, 255)));
            else if (r < 10)
                send_item(FUNC_UNUSED, 10'($urandom_range(0, 1023)),
                          8'($urandom_range(0, 255)));
            else if (r < 12)
                settle_all();
            else
                random_transfer();
        end
        settle_all();
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        test_reset_timeout();
        test_directed_response();
        test_directed_block();
        test_large_count();
        test_long_timeout();

        load_timeout(16'd1);
        test_random_mix(100, 25, 25);
        load_timeout(16'($urandom_range(2, 8)));
        test_random_mix(90, 10, 50);
        load_timeout(16'hFFFF);
        test_random_mix(60, 40, 10);
        load_timeout(16'($urandom_range(1, 4)));
        test_random_mix(80, 0, 0);

        $display("run covered %0d items accepted and %0d results checked",
                 items_in, results_seen);
        $display("transfer ends: ok %0d, timeout %0d, bad R1 %0d, bad token %0d, bad count %0d",
                 ends_by_status[0], ends_by_status[1], ends_by_status[2],
                 ends_by_status[3], ends_by_status[4]);
        if (mismatches == 0 && host_results_q.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // Watchdog
    initial
    begin
        #RUN_LIMIT;
        $display("run limit reached, %0d results pending", host_results_q.size());
        $display("FAIL");
        $finish;
    end

endmodule
